>>> hdl/mcfe_pkg.sv
// Package for the motor command frame encoder: transaction types, frame constants,
// configuration register indexes and their reset values.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package mcfe_pkg;

    // Configuration register indexes.
    localparam logic [3:0] CFG_GEAR_RATIO   = 4'd0;
    localparam logic [3:0] CFG_GEAR_INVERSE = 4'd1;

    localparam logic [15:0] RATIO_RESET   = 16'd37274;
    localparam logic [15:0] INVERSE_RESET = 16'd7202;

    // Frame layout and check code.
    localparam logic [7:0]  SYNC_FIRST  = 8'hFE;
    localparam logic [7:0]  SYNC_SECOND = 8'hEE;
    localparam logic [7:0]  HDR_TRAILER = 8'hFF;
    localparam logic [5:0]  LAST_INDEX  = 6'd33;
    localparam logic [5:0]  CRC_END     = 6'd28;
    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]         motor_id;
        logic [7:0]         op_mode;
        logic signed [15:0] torque_scaled;
        logic signed [15:0] speed_scaled;
        logic signed [31:0] position_counts;
        logic [15:0]        stiffness_scaled;
        logic [15:0]        damping_scaled;
    } cmd_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic       last_of_frame;
    } frame_out_t;

    // Command after gear scaling, as it is laid into the frame.
    typedef struct packed {
        logic [7:0]  motor_id;
        logic [7:0]  op_mode;
        logic [15:0] torque;
        logic [15:0] speed;
        logic [31:0] position;
        logic [15:0] stiffness;
        logic [15:0] damping;
    } cmd_scaled_t;

endpackage

>>> hdl/mcfe_scale.sv
// Gear scaling stage: input register, fixed-point multiply with truncation toward
// zero and saturation, and the scaled command register. Depends on mcfe_pkg.
`timescale 1ns / 1ps

module mcfe_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          gear_ratio_q12,
    input  logic [15:0]          gear_inverse_q16,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mcfe_pkg::cmd_in_t    in_data,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output mcfe_pkg::cmd_scaled_t cmd_data
);

    logic                  in_valid_reg;
    mcfe_pkg::cmd_in_t     in_data_reg;
    logic                  cmd_valid_reg;
    mcfe_pkg::cmd_scaled_t cmd_data_reg;
    mcfe_pkg::cmd_scaled_t cmd_data_next;
    logic                  cmd_load;

    logic        tq_neg, sp_neg, ps_neg;
    logic [15:0] tq_mag, sp_mag;
    logic [31:0] ps_mag;
    logic [31:0] tq_prod, sp_prod;
    logic [47:0] ps_prod;

    function automatic logic [15:0] sat16(input logic neg, input logic [35:0] q);
        if (!neg) begin
            return (q > 36'h0_0000_7FFF) ? 16'h7FFF : q[15:0];
        end
        return (q > 36'h0_0000_8000) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [35:0] q);
        if (!neg) begin
            return (q > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return (q > 36'h0_8000_0000) ? 32'h8000_0000 : 32'(~q[31:0] + 32'd1);
    endfunction

    assign cmd_load  = in_valid_reg && (!cmd_valid_reg || cmd_ready);
    assign in_ready  = !in_valid_reg || cmd_load;
    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_data_reg;

    // Magnitudes are scaled and the sign restored afterwards, so products round
    // toward zero. The magnitude of the most negative value still fits unsigned.
    always_comb begin
        tq_neg  = in_data_reg.torque_scaled[15];
        sp_neg  = in_data_reg.speed_scaled[15];
        ps_neg  = in_data_reg.position_counts[31];
        tq_mag  = tq_neg ? 16'(~in_data_reg.torque_scaled + 16'd1) : in_data_reg.torque_scaled;
        sp_mag  = sp_neg ? 16'(~in_data_reg.speed_scaled + 16'd1) : in_data_reg.speed_scaled;
        ps_mag  = ps_neg ? 32'(~in_data_reg.position_counts + 32'd1)
                         : in_data_reg.position_counts;
        tq_prod = 32'(tq_mag) * 32'(gear_inverse_q16);
        sp_prod = 32'(sp_mag) * 32'(gear_ratio_q12);
        ps_prod = 48'(ps_mag) * 48'(gear_ratio_q12);

        cmd_data_next.motor_id  = in_data_reg.motor_id;
        cmd_data_next.op_mode   = in_data_reg.op_mode;
        cmd_data_next.torque    = sat16(tq_neg, 36'(tq_prod[31:16]));
        cmd_data_next.speed     = sat16(sp_neg, 36'(sp_prod[31:12]));
        cmd_data_next.position  = sat32(ps_neg, ps_prod[47:12]);
        cmd_data_next.stiffness = in_data_reg.stiffness_scaled;
        cmd_data_next.damping   = in_data_reg.damping_scaled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (!cmd_valid_reg || cmd_ready) begin
                cmd_valid_reg <= in_valid_reg;
            end
        end
        if (in_valid && in_ready) begin
            in_data_reg <= in_data;
        end
        if (cmd_load) begin
            cmd_data_reg <= cmd_data_next;
        end
    end

endmodule

>>> hdl/mcfe_serial.sv
// Frame serialiser: sends one scaled command as 34 bytes, one per cycle while not
// stalled; the CRC folds one byte per cycle over bytes 0-27. Depends on mcfe_pkg.
`timescale 1ns / 1ps

module mcfe_serial (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  mcfe_pkg::cmd_scaled_t cmd_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mcfe_pkg::frame_out_t  out_data
);

    localparam logic [5:0] POS_SYNC_FIRST  = 6'd0;
    localparam logic [5:0] POS_SYNC_SECOND = 6'd1;
    localparam logic [5:0] POS_ID          = 6'd2;
    localparam logic [5:0] POS_MODE        = 6'd4;
    localparam logic [5:0] POS_TRAILER     = 6'd5;
    localparam logic [5:0] POS_TORQUE      = 6'd12;
    localparam logic [5:0] POS_SPEED       = 6'd14;
    localparam logic [5:0] POS_POSITION    = 6'd16;
    localparam logic [5:0] POS_STIFFNESS   = 6'd20;
    localparam logic [5:0] POS_DAMPING     = 6'd22;
    localparam logic [5:0] POS_CRC         = 6'd30;

    logic                  active_reg;
    mcfe_pkg::cmd_scaled_t cur_reg;
    logic [5:0]            cnt_reg;
    logic [31:0]           crc_reg;
    logic [31:0]           crc_next;
    logic                  out_valid_reg;
    mcfe_pkg::frame_out_t  out_data_reg;
    mcfe_pkg::frame_out_t  out_data_next;
    logic                  advance;
    logic                  last_now;
    logic                  load;
    logic [5:0]            feed_idx;

    function automatic logic [7:0] byte_at(input mcfe_pkg::cmd_scaled_t f,
                                           input logic [31:0] crc,
                                           input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            POS_SYNC_FIRST:     b = mcfe_pkg::SYNC_FIRST;
            POS_SYNC_SECOND:    b = mcfe_pkg::SYNC_SECOND;
            POS_ID:             b = f.motor_id;
            POS_MODE:           b = f.op_mode;
            POS_TRAILER:        b = mcfe_pkg::HDR_TRAILER;
            POS_TORQUE:         b = f.torque[7:0];
            POS_TORQUE + 6'd1:  b = f.torque[15:8];
            POS_SPEED:          b = f.speed[7:0];
            POS_SPEED + 6'd1:   b = f.speed[15:8];
            POS_POSITION:       b = f.position[7:0];
            POS_POSITION + 6'd1: b = f.position[15:8];
            POS_POSITION + 6'd2: b = f.position[23:16];
            POS_POSITION + 6'd3: b = f.position[31:24];
            POS_STIFFNESS:      b = f.stiffness[7:0];
            POS_STIFFNESS + 6'd1: b = f.stiffness[15:8];
            POS_DAMPING:        b = f.damping[7:0];
            POS_DAMPING + 6'd1: b = f.damping[15:8];
            POS_CRC:            b = crc[7:0];
            POS_CRC + 6'd1:     b = crc[15:8];
            POS_CRC + 6'd2:     b = crc[23:16];
            POS_CRC + 6'd3:     b = crc[31:24];
            default:            b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        top;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            top = c[31] ^ b[i];
            c   = {c[30:0], 1'b0} ^ (top ? mcfe_pkg::CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    assign advance   = active_reg && (!out_valid_reg || out_ready);
    assign last_now  = (cnt_reg == mcfe_pkg::LAST_INDEX);
    assign cmd_ready = !active_reg || (advance && last_now);
    assign load      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Words are assembled least significant byte first but fed most significant
    // bit first, so within each group of four the bytes enter in reverse order.
    assign feed_idx = {cnt_reg[5:2], ~cnt_reg[1:0]};
    assign crc_next = crc_byte(crc_reg, byte_at(cur_reg, crc_reg, feed_idx));

    always_comb begin
        out_data_next.frame_byte    = byte_at(cur_reg, crc_reg, cnt_reg);
        out_data_next.byte_index    = cnt_reg;
        out_data_next.last_of_frame = last_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
                cnt_reg    <= 6'd0;
                crc_reg    <= mcfe_pkg::CRC_INIT;
                cur_reg    <= cmd_data;
            end else if (advance) begin
                cnt_reg <= 6'(cnt_reg + 6'd1);
                if (cnt_reg < mcfe_pkg::CRC_END) begin
                    crc_reg <= crc_next;
                end
                if (last_now) begin
                    active_reg <= 1'b0;
                end
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/motor_command_frame_encoder.sv
// Top level of the motor command frame encoder: configuration registers, the gear
// scaling stage and the frame serialiser. Depends on mcfe_pkg, mcfe_scale, mcfe_serial.
//
//   Port group   Direction  Carries
//   s_*          in         one motor command per transaction (mcfe_pkg::cmd_in_t)
//   m_*          out        one frame byte per transaction (mcfe_pkg::frame_out_t)
//   cfg_*        in         register index and 16-bit write data
//
// Each command yields 34 output bytes, one per cycle while m_ready is held high, so the
// byte serialiser limits how fast commands go through. On its way to the first byte a
// command passes the input, scaled-command, frame and output registers.
// Up to two further commands are taken while a frame is still being sent.
// Reset is synchronous and active low and clears all valid flags; no clearing pass.
// A stall on m_ready holds the current byte and the CRC fold with it.
`timescale 1ns / 1ps

module motor_command_frame_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcfe_pkg::cmd_in_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mcfe_pkg::frame_out_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0]           gear_ratio_reg;
    logic [15:0]           gear_inverse_reg;
    logic                  cmd_valid;
    logic                  cmd_ready;
    mcfe_pkg::cmd_scaled_t cmd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gear_ratio_reg   <= mcfe_pkg::RATIO_RESET;
            gear_inverse_reg <= mcfe_pkg::INVERSE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == mcfe_pkg::CFG_GEAR_RATIO) begin
                gear_ratio_reg <= cfg_data;
            end else if (cfg_index == mcfe_pkg::CFG_GEAR_INVERSE) begin
                gear_inverse_reg <= cfg_data;
            end
        end
    end

    mcfe_scale u_scale (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .gear_ratio_q12   (gear_ratio_reg),
        .gear_inverse_q16 (gear_inverse_reg),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_data          (s_data),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd_data         (cmd_data)
    );

    mcfe_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

>>> hdl/mcfe_checker.sv
// Port-level checks for the motor command frame encoder, attached by bind.
// Depends on mcfe_pkg and the top level motor_command_frame_encoder.
`timescale 1ns / 1ps

module mcfe_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input mcfe_pkg::frame_out_t m_data
);

    // A stalled byte transaction keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output byte changed while stalled");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_frame == (m_data.byte_index == mcfe_pkg::LAST_INDEX)))
        else $error("last_of_frame does not match byte_index");

    // Within a frame the bytes follow one another without a gap.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_frame |=>
            m_valid && (m_data.byte_index == 6'($past(m_data.byte_index) + 6'd1)))
        else $error("frame byte index did not advance by one");

    a_sync_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.byte_index == 6'd0) |-> (m_data.frame_byte == mcfe_pkg::SYNC_FIRST))
        else $error("frame does not open with the sync byte");

    a_first_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_of_frame ##1 m_valid |-> (m_data.byte_index == 6'd0))
        else $error("new frame does not start at byte zero");

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
